// ----- rtl/vch_pkg.sv -----
// Shared widths, codes and hash constants of the voxel coordinate hash table.
`timescale 1ns / 1ps

package vch_pkg;

  localparam int REQ_TYPE_W = 2;
  localparam int COORD_W    = 16;
  localparam int ENTRY_W    = 24;
  localparam int RESULT_W   = 24;
  localparam int CFG_W      = 4;
  localparam int KEY_W      = 4 * COORD_W;

  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int VALUE_BITS_DEF  = 24;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd12;

  localparam logic [REQ_TYPE_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR  = 2'd2;

  localparam logic [KEY_W-1:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [KEY_W-1:0] MIX_C2 = 64'h94d049bb133111eb;

endpackage

// ----- rtl/vch_if.sv -----
// Handshake channels of the voxel coordinate hash table: request, response, configuration.
`timescale 1ns / 1ps

interface vch_req_if;
  logic                            valid;
  logic                            ready;
  logic [vch_pkg::REQ_TYPE_W-1:0]  req_type;
  logic [vch_pkg::COORD_W-1:0]     batch_index;
  logic [vch_pkg::COORD_W-1:0]     coord_x;
  logic [vch_pkg::COORD_W-1:0]     coord_y;
  logic [vch_pkg::COORD_W-1:0]     coord_z;
  logic [vch_pkg::ENTRY_W-1:0]     entry_value;

  modport source (output valid, req_type, batch_index, coord_x, coord_y, coord_z,
                  entry_value, input ready);
  modport sink (input valid, req_type, batch_index, coord_x, coord_y, coord_z,
                entry_value, output ready);
endinterface

interface vch_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [vch_pkg::RESULT_W-1:0]   result_value;
  logic                           status;

  modport source (output valid, found, result_value, status, input ready);
  modport sink (input valid, found, result_value, status, output ready);
endinterface

interface vch_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [vch_pkg::CFG_W-1:0]   table_size_log2;

  modport source (output valid, table_size_log2, input ready);
  modport sink (input valid, table_size_log2, output ready);
endinterface

// ----- rtl/voxel_coord_hash_table.sv -----
// Top level of the voxel coordinate hash table: request control and slot stores.
`timescale 1ns / 1ps

// The block maps 4-D voxel coordinates to row indices in an open-addressing table with
// linear probing. One request is handled at a time. An insert or lookup hashes the key
// with splitmix64 on one shared 32x32 multiplier, then probes slots; the key store's
// single read port gives one probe per cycle. A clear request sweeps every slot, one per
// cycle. After reset the same sweep runs before the first request is accepted;
// configuration writes are taken at any time. A finished response waits in an output
// register while the next request is accepted.
module voxel_coord_hash_table #(
  parameter int TABLE_DEPTH = vch_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_BITS  = vch_pkg::VALUE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  vch_req_if.sink    req_i,
  vch_rsp_if.source  rsp_o,
  vch_cfg_if.sink    cfg_i
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int LG_FIT = $clog2(TABLE_DEPTH + 1) - 1;
  localparam int LG_TOP = (1 << vch_pkg::CFG_W) - 1;
  localparam int LG_CAP = (LG_FIT < LG_TOP) ? LG_FIT : LG_TOP;
  localparam int KW     = vch_pkg::KEY_W;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_PROBE,
    ST_CLEAR,
    ST_RESP
  } state_e;

  state_e                        state_q;
  logic [vch_pkg::CFG_W-1:0]     cfg_q;
  logic [ADDR_W-1:0]             sweep_q;
  logic [ADDR_W-1:0]             slot_q;
  logic [ADDR_W-1:0]             count_q;
  logic [KW-1:0]                 key_q;
  logic                          insert_q;
  logic [VALUE_BITS-1:0]         value_q;
  logic                          found_q;
  logic [vch_pkg::RESULT_W-1:0]  rval_q;
  logic                          status_q;
  logic                          out_valid_q;
  logic                          out_found_q;
  logic [vch_pkg::RESULT_W-1:0]  out_rval_q;
  logic                          out_status_q;

  logic [vch_pkg::CFG_W-1:0]     lg_eff;
  logic [ADDR_W:0]               span;
  logic [ADDR_W-1:0]             mask;
  logic [ADDR_W-1:0]             slot_next;
  logic [KW-1:0]                 key_d;
  logic                          req_acc;
  logic                          hash_start;
  logic                          hash_done;
  logic [KW-1:0]                 hash;
  logic                          sweeping;
  logic                          kram_we;
  logic [ADDR_W-1:0]             kram_waddr;
  logic [KW:0]                   kram_wdata;
  logic [ADDR_W-1:0]             ram_raddr;
  logic [KW:0]                   kram_rdata;
  logic                          vram_we;
  logic [VALUE_BITS-1:0]         vram_rdata;
  logic                          slot_used;
  logic                          key_hit;

  always_comb begin
    lg_eff = cfg_q;
    if (cfg_q == '0) begin
      lg_eff = vch_pkg::CFG_W'(1);
    end else if (32'(cfg_q) > LG_CAP) begin
      lg_eff = vch_pkg::CFG_W'(LG_CAP);
    end
    span = (ADDR_W + 1)'(1) << lg_eff;
    mask = span[ADDR_W-1:0] - ADDR_W'(1);
  end

  assign slot_next  = (slot_q + ADDR_W'(1)) & mask;
  assign key_d      = {req_i.batch_index, req_i.coord_x, req_i.coord_y, req_i.coord_z}
                      + KW'(1);
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign hash_start  = req_acc && ((req_i.req_type == vch_pkg::REQ_INSERT) ||
                                   (req_i.req_type == vch_pkg::REQ_LOOKUP));
  assign cfg_i.ready = 1'b1;

  assign sweeping   = (state_q == ST_INIT) || (state_q == ST_CLEAR);
  assign slot_used  = kram_rdata[KW];
  assign key_hit    = slot_used && (kram_rdata[KW-1:0] == key_q);
  assign ram_raddr  = (state_q == ST_PROBE) ? slot_next : slot_q;

  assign kram_we    = sweeping || ((state_q == ST_PROBE) && insert_q && !slot_used);
  assign kram_waddr = sweeping ? sweep_q : slot_q;
  assign kram_wdata = sweeping ? '0 : {1'b1, key_q};
  assign vram_we    = (state_q == ST_PROBE) && insert_q && (!slot_used || key_hit);

  vch_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (key_d),
    .done_o  (hash_done),
    .hash_o  (hash)
  );

  vch_ram #(
    .WIDTH (KW + 1),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (kram_we),
    .waddr_i (kram_waddr),
    .wdata_i (kram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (kram_rdata)
  );

  vch_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .waddr_i (slot_q),
    .wdata_i (value_q),
    .raddr_i (ram_raddr),
    .rdata_o (vram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      cfg_q        <= vch_pkg::CFG_RESET;
      sweep_q      <= '0;
      slot_q       <= '0;
      count_q      <= '0;
      key_q        <= '0;
      insert_q     <= 1'b0;
      value_q      <= '0;
      found_q      <= 1'b0;
      rval_q       <= '0;
      status_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_found_q  <= 1'b0;
      out_rval_q   <= '0;
      out_status_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        cfg_q <= cfg_i.table_size_log2;
      end
      if (rsp_o.ready && (state_q != ST_RESP)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_INIT, ST_CLEAR: begin
          if (sweep_q == ADDR_W'(TABLE_DEPTH - 1)) begin
            sweep_q <= '0;
            state_q <= (state_q == ST_INIT) ? ST_IDLE : ST_RESP;
          end else begin
            sweep_q <= sweep_q + ADDR_W'(1);
          end
        end
        ST_IDLE: begin
          if (req_acc) begin
            key_q    <= key_d;
            insert_q <= (req_i.req_type == vch_pkg::REQ_INSERT);
            value_q  <= VALUE_BITS'(req_i.entry_value);
            found_q  <= 1'b0;
            rval_q   <= '0;
            status_q <= 1'b0;
            case (req_i.req_type)
              vch_pkg::REQ_INSERT, vch_pkg::REQ_LOOKUP: state_q <= ST_HASH;
              vch_pkg::REQ_CLEAR:                       state_q <= ST_CLEAR;
              default:                                  state_q <= ST_RESP;
            endcase
          end
        end
        ST_HASH: begin
          if (hash_done) begin
            slot_q  <= hash[ADDR_W-1:0] & mask;
            count_q <= '0;
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_PROBE;
        end
        ST_PROBE: begin
          if (!slot_used) begin
            found_q <= insert_q;
            state_q <= ST_RESP;
          end else if (key_hit) begin
            found_q <= 1'b1;
            rval_q  <= insert_q ? '0 : vch_pkg::RESULT_W'(vram_rdata);
            state_q <= ST_RESP;
          end else if (count_q == mask) begin
            status_q <= insert_q;
            state_q  <= ST_RESP;
          end else begin
            slot_q  <= slot_next;
            count_q <= count_q + ADDR_W'(1);
          end
        end
        ST_RESP: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q  <= 1'b1;
            out_found_q  <= found_q;
            out_rval_q   <= rval_q;
            out_status_q <= status_q;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.found        = out_found_q;
  assign rsp_o.result_value = out_rval_q;
  assign rsp_o.status       = out_status_q;

endmodule

// ----- rtl/vch_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module vch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/vch_hash.sv -----
// Iterative splitmix64 finalizer built around one shared 32x32 multiplier.
`timescale 1ns / 1ps

module vch_hash (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [vch_pkg::KEY_W-1:0] key_i,
  output logic                      done_o,
  output logic [vch_pkg::KEY_W-1:0] hash_o
);

  localparam int HW = vch_pkg::KEY_W / 2;

  logic                      busy_q;
  logic [2:0]                step_q;
  logic                      done_q;
  logic [vch_pkg::KEY_W-1:0] a_q;
  logic [vch_pkg::KEY_W-1:0] acc_q;
  logic [vch_pkg::KEY_W-1:0] acc_d;
  logic [vch_pkg::KEY_W-1:0] hash_q;
  logic [vch_pkg::KEY_W-1:0] mult_c;
  logic [HW-1:0]             op_a;
  logic [HW-1:0]             op_b;
  logic [vch_pkg::KEY_W-1:0] prod;

  // Each 64-bit product keeps its low half: lo*lo, then the two cross terms.
  always_comb begin
    mult_c = (step_q >= 3'd3) ? vch_pkg::MIX_C2 : vch_pkg::MIX_C1;
    op_a   = a_q[HW-1:0];
    op_b   = mult_c[HW-1:0];
    case (step_q)
      3'd1, 3'd4: op_a = a_q[vch_pkg::KEY_W-1:HW];
      3'd2, 3'd5: op_b = mult_c[vch_pkg::KEY_W-1:HW];
      default: ;
    endcase
    prod = vch_pkg::KEY_W'(op_a) * vch_pkg::KEY_W'(op_b);
    case (step_q)
      3'd0, 3'd3: acc_d = prod;
      default:    acc_d = {acc_q[vch_pkg::KEY_W-1:HW] + prod[HW-1:0], acc_q[HW-1:0]};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'd5) begin
          busy_q <= 1'b0;
        end
      end
      done_q <= !start_i && busy_q && (step_q == 3'd5);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= key_i ^ (key_i >> 30);
    end else if (busy_q) begin
      acc_q <= acc_d;
      if (step_q == 3'd2) begin
        a_q <= acc_d ^ (acc_d >> 27);
      end
      if (step_q == 3'd5) begin
        hash_q <= acc_d ^ (acc_d >> 31);
      end
    end
  end

  assign done_o = done_q;
  assign hash_o = hash_q;

endmodule
